### src/sf3_pkg.sv
// Shared types, constants and helpers for the spring force block.
// No dependencies; front, queue, back and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package sf3_pkg;

	localparam int VEC_W  = 32;
	localparam int SUM_W  = 64;
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// configuration register indexes
	localparam logic CFG_SPRING_CONSTANT = 1'b0;
	localparam logic CFG_REST_LENGTH     = 1'b1;

	// one entry of the queue between front and back
	typedef struct packed {
		logic [2:0][VEC_W-1:0] d;     // clamped differences, signed
		logic [SUM_W-1:0]      sum;   // dx^2 + dy^2 + dz^2
		logic                  sat;   // a difference was clamped
	} diff_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [VEC_W-1:0] mag32(input logic [VEC_W-1:0] v);
		logic [VEC_W-1:0] r;
		r = v[VEC_W-1] ? (~v + 32'd1) : v;
		return r;
	endfunction

endpackage

### src/sf3_if.sv
// Valid/ready channel interfaces for the spring force block.
// Depends on nothing; payload widths follow the Q16.16 field formats.
`timescale 1ns / 1ps

interface sf3_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] end_x;
	logic signed [31:0] end_y;
	logic signed [31:0] end_z;

	modport source (output valid, pos_x, pos_y, pos_z, end_x, end_y, end_z, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, end_x, end_y, end_z, output ready);
endinterface

interface sf3_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic signed [31:0] force_z;
	logic               zero_length;
	logic               saturated;

	modport source (output valid, force_x, force_y, force_z, zero_length, saturated,
		input ready);
	modport sink (input valid, force_x, force_y, force_z, zero_length, saturated,
		output ready);
endinterface

### src/sf3_front.sv
// Front end: accepts input transactions, forms clamped differences and squared length.
// Depends on sf3_pkg and sf3_in_if.
`timescale 1ns / 1ps

module sf3_front (
	input  logic          clk,
	input  logic          arst_n,
	sf3_in_if.sink        items,
	output logic          push,
	output sf3_pkg::diff_t push_data,
	input  sf3_pkg::q_stat_t q_stat
);

	logic                         v_s1, v_s2, v_s3;
	logic [2:0][31:0]             d_s1, d_s2, d_s3;
	logic                         sat_s1, sat_s2, sat_s3;
	logic [2:0][63:0]             sq_s2;
	logic [63:0]                  sum_s3;
	logic                         fen;
	logic [2:0][31:0]             pos_v, end_v, d_n;
	logic [2:0]                   sat_n;

	assign fen         = !(v_s3 && q_stat.full);
	assign items.ready = fen;
	assign push        = v_s3 && !q_stat.full;
	assign push_data   = '{d: d_s3, sum: sum_s3, sat: sat_s3};

	assign pos_v = {items.pos_z, items.pos_y, items.pos_x};
	assign end_v = {items.end_z, items.end_y, items.end_x};

	always_comb begin
		logic signed [32:0] df;
		for (int i = 0; i < 3; i++) begin
			df = $signed({pos_v[i][31], pos_v[i]}) - $signed({end_v[i][31], end_v[i]});
			sat_n[i] = 1'b0;
			if (df[32] != df[31]) begin
				sat_n[i] = 1'b1;
				d_n[i]   = df[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				d_n[i] = df[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (fen) begin
			v_s1 <= items.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fen) begin
			d_s1   <= d_n;
			sat_s1 <= |sat_n;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= 64'(sf3_pkg::mag32(d_s1[i])) * 64'(sf3_pkg::mag32(d_s1[i]));
			end
			d_s2   <= d_s1;
			sat_s2 <= sat_s1;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			d_s3   <= d_s2;
			sat_s3 <= sat_s2;
		end
	end

endmodule

### src/sf3_queue.sv
// Short FIFO between front and back so each side stalls on its own.
// Depends on sf3_pkg.
`timescale 1ns / 1ps

module sf3_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sf3_pkg::diff_t   push_data,
	input  logic             pop,
	output sf3_pkg::diff_t   head,
	output sf3_pkg::q_stat_t stat
);

	sf3_pkg::diff_t               mem_q [sf3_pkg::QDEPTH];
	logic [sf3_pkg::QAW-1:0]      wr_q, rd_q;
	logic [sf3_pkg::QAW:0]        cnt_q;

	assign stat.full  = cnt_q == (sf3_pkg::QAW+1)'(sf3_pkg::QDEPTH);
	assign stat.empty = cnt_q == '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (sf3_pkg::QAW+1)'(push) - (sf3_pkg::QAW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

### src/sf3_back.sv
// Back end: pipelined square root, divide and multiply, then saturation into the result.
// Depends on sf3_pkg and sf3_out_if.
`timescale 1ns / 1ps

module sf3_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [31:0]    spring_constant,
	input  logic [30:0]    rest_length,
	input  sf3_pkg::diff_t head,
	input  logic           head_valid,
	output logic           pop,
	sf3_out_if.source      results
);

	localparam int MW = 64 - FRAC_BITS;   // width of k*|e| after scaling
	localparam int RW = 33 + FRAC_BITS;   // divider remainder
	localparam int QW = FRAC_BITS + 1;    // unit component, up to 1.0
	localparam int DS = FRAC_BITS + 1;    // divider stages
	localparam int PW = 32 + QW;          // low partial product
	localparam int HW = MW - 32 + QW;     // high partial product
	localparam int FW = 65 - FRAC_BITS;   // force magnitude

	typedef struct packed {
		logic [63:0]      rem;
		logic [31:0]      root;
		logic [2:0][31:0] d;
		logic             sat;
	} sq_t;

	typedef struct packed {
		logic [2:0][RW-1:0] rem;
		logic [2:0][QW-1:0] q;
		logic [31:0]        len;
		logic [MW-1:0]      m;
		logic               e_neg;
		logic [2:0]         d_neg;
		logic               zl;
		logic               sat;
	} dv_t;

	logic ben;
	logic v_sq [33];
	sq_t  sq_s [33];
	logic v_dv [DS+1];
	dv_t  dv_s [DS+1];

	logic               v_p1;
	logic [2:0][PW-1:0] pl_p1;
	logic [2:0][HW-1:0] ph_p1;
	logic               e_neg_p1, zl_p1, sat_p1;
	logic [2:0]         d_neg_p1;

	logic               out_v_q;
	logic [2:0][31:0]   force_q;
	logic               zl_q, sat_q;

	assign ben = !out_v_q || results.ready;
	assign pop = ben && head_valid;

	assign results.valid       = out_v_q;
	assign results.force_x     = force_q[0];
	assign results.force_y     = force_q[1];
	assign results.force_z     = force_q[2];
	assign results.zero_length = zl_q;
	assign results.saturated   = sat_q;

	// stage 0 takes the queue head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sq[0] <= 1'b0;
		else if (ben) v_sq[0] <= head_valid;
	end

	always_ff @(posedge clk) begin
		if (ben) sq_s[0] <= '{rem: head.sum, root: 32'd0, d: head.d, sat: head.sat};
	end

	// square root, one result bit per stage, remainder form
	for (genvar k = 0; k < 32; k++) begin : g_sqrt
		localparam int J = 31 - k;
		logic [65:0] trial;
		assign trial = ({34'd0, sq_s[k].root} << (J + 1)) + (66'd1 << (2 * J));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sq[k+1] <= 1'b0;
			else if (ben) v_sq[k+1] <= v_sq[k];
		end

		always_ff @(posedge clk) begin
			if (ben) begin
				sq_s[k+1].d   <= sq_s[k].d;
				sq_s[k+1].sat <= sq_s[k].sat;
				if ({2'b00, sq_s[k].rem} >= trial) begin
					sq_s[k+1].rem  <= sq_s[k].rem - trial[63:0];
					sq_s[k+1].root <= sq_s[k].root | (32'd1 << J);
				end else begin
					sq_s[k+1].rem  <= sq_s[k].rem;
					sq_s[k+1].root <= sq_s[k].root;
				end
			end
		end
	end

	// length error, k*|e| and divider setup
	logic signed [32:0] e_n;
	logic [31:0]        e_mag;
	logic [63:0]        m_full;

	always_comb begin
		e_n    = $signed({2'b00, rest_length}) - $signed({1'b0, sq_s[32].root});
		e_mag  = e_n[32] ? 32'(-e_n) : e_n[31:0];
		m_full = 64'(spring_constant) * 64'(e_mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_dv[0] <= 1'b0;
		else if (ben) v_dv[0] <= v_sq[32];
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			for (int i = 0; i < 3; i++) begin
				dv_s[0].rem[i] <= {1'b0, sf3_pkg::mag32(sq_s[32].d[i]), FRAC_BITS'(0)};
				dv_s[0].d_neg[i] <= sq_s[32].d[i][31];
			end
			dv_s[0].q     <= '0;
			dv_s[0].len   <= sq_s[32].root;
			dv_s[0].m     <= m_full[63:FRAC_BITS];
			dv_s[0].e_neg <= e_n[32];
			dv_s[0].zl    <= sq_s[32].root == 32'd0;
			dv_s[0].sat   <= sq_s[32].sat;
		end
	end

	// restoring divide, three lanes, one quotient bit per stage
	for (genvar t = 0; t < DS; t++) begin : g_div
		localparam int B = FRAC_BITS - t;
		logic [RW-1:0] dsr;
		assign dsr = RW'(dv_s[t].len) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_dv[t+1] <= 1'b0;
			else if (ben) v_dv[t+1] <= v_dv[t];
		end

		always_ff @(posedge clk) begin
			if (ben) begin
				dv_s[t+1].len   <= dv_s[t].len;
				dv_s[t+1].m     <= dv_s[t].m;
				dv_s[t+1].e_neg <= dv_s[t].e_neg;
				dv_s[t+1].d_neg <= dv_s[t].d_neg;
				dv_s[t+1].zl    <= dv_s[t].zl;
				dv_s[t+1].sat   <= dv_s[t].sat;
				for (int i = 0; i < 3; i++) begin
					if (dv_s[t].rem[i] >= dsr) begin
						dv_s[t+1].rem[i] <= dv_s[t].rem[i] - dsr;
						dv_s[t+1].q[i]   <= dv_s[t].q[i] | (QW'(1) << B);
					end else begin
						dv_s[t+1].rem[i] <= dv_s[t].rem[i];
						dv_s[t+1].q[i]   <= dv_s[t].q[i];
					end
				end
			end
		end
	end

	// m * u split into two partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_p1 <= 1'b0;
		else if (ben) v_p1 <= v_dv[DS];
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			for (int i = 0; i < 3; i++) begin
				pl_p1[i] <= PW'(dv_s[DS].m[31:0]) * PW'(dv_s[DS].q[i]);
				ph_p1[i] <= HW'(dv_s[DS].m[MW-1:32]) * HW'(dv_s[DS].q[i]);
			end
			e_neg_p1 <= dv_s[DS].e_neg;
			d_neg_p1 <= dv_s[DS].d_neg;
			zl_p1    <= dv_s[DS].zl;
			sat_p1   <= dv_s[DS].sat;
		end
	end

	// combine, sign and clamp into the result register
	logic [2:0][31:0] f_n;
	logic [2:0]       fsat_n;

	always_comb begin
		logic [64:0]   comb;
		logic [FW-1:0] fm;
		logic          neg;
		for (int i = 0; i < 3; i++) begin
			comb      = {ph_p1[i][32:0], 32'd0} + 65'(pl_p1[i]);
			fm        = comb[64:FRAC_BITS];
			neg       = (e_neg_p1 != d_neg_p1[i]) && (fm != '0);
			fsat_n[i] = 1'b0;
			if (neg) begin
				if (fm > FW'(33'h0_8000_0000)) begin
					fsat_n[i] = 1'b1;
					f_n[i]    = 32'h8000_0000;
				end else begin
					f_n[i] = ~fm[31:0] + 32'd1;
				end
			end else begin
				if (fm > FW'(33'h0_7FFF_FFFF)) begin
					fsat_n[i] = 1'b1;
					f_n[i]    = 32'h7FFF_FFFF;
				end else begin
					f_n[i] = fm[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (ben) out_v_q <= v_p1;
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			if (zl_p1) begin
				force_q <= '0;
				zl_q    <= 1'b1;
				sat_q   <= 1'b0;
			end else begin
				force_q <= f_n;
				zl_q    <= 1'b0;
				sat_q   <= sat_p1 || (|fsat_n);
			end
		end
	end

endmodule

### src/spring_force_3d_core.sv
// Top level of the 3D Hooke spring force block: config registers, front, queue, back.
// Depends on sf3_pkg, sf3_if, sf3_front, sf3_queue and sf3_back.
`timescale 1ns / 1ps

// channel   dir  handshake     payload
// items     in   valid/ready   pos_x pos_y pos_z end_x end_y end_z (signed Q16.16)
// results   out  valid/ready   force_x force_y force_z (signed Q16.16), zero_length, saturated
// cfg       in   cfg_we only   cfg_index (0 k, 1 rest length), cfg_data
//
// One transaction per cycle sustained while results.ready stays high, fully pipelined.
// Stages in order: 3 front stages, the queue, 1 load stage,
// 32 square root stages, 1 error/multiply stage, FRAC_BITS+1 divide stages, 2 output stages.
// The back pipeline advances as a whole and stalls only when the result register is held;
// the 4-entry queue then absorbs the front's items before items.ready drops.
// Reset clears valid bits, queue pointers and both config registers.

module spring_force_3d_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	sf3_in_if.sink      items,
	sf3_out_if.source   results,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] k_q;
	logic [30:0] rest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= '0;
			rest_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sf3_pkg::CFG_SPRING_CONSTANT: k_q <= cfg_data;
				sf3_pkg::CFG_REST_LENGTH:     rest_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// front -> queue
	logic             push;
	sf3_pkg::diff_t   push_data;
	sf3_pkg::q_stat_t q_stat;

	// queue -> back
	logic             pop;
	sf3_pkg::diff_t   head;

	sf3_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.push      (push),
		.push_data (push_data),
		.q_stat    (q_stat)
	);

	sf3_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	sf3_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.spring_constant (k_q),
		.rest_length     (rest_q),
		.head            (head),
		.head_valid      (!q_stat.empty),
		.pop             (pop),
		.results         (results)
	);

endmodule

### bench/spring_force_3d_core_test.sv
// Self-checking bench for spring_force_3d_core: directed table, then random traffic.
// Depends on sf3_pkg, sf3_in_if/sf3_out_if and the spring_force_3d_core RTL in src.
`timescale 1ns / 1ps

module spring_force_3d_core_test;

	localparam int FRAC = 16;

	// one particle/end pair as driven on the item channel
	typedef struct {
		logic signed [31:0] px, py, pz;
		logic signed [31:0] ex, ey, ez;
	} pair_t;

	// one force result as seen on the result channel
	typedef struct {
		logic signed [31:0] fx, fy, fz;
		logic               zl;
		logic               sat;
	} force_t;

	// directed row: register setting, stimulus, and optionally a typed-in answer
	typedef struct {
		logic [31:0] k;
		logic [31:0] rest;
		pair_t       p;
		bit          typed;
		force_t      f;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [31:0] cfg_data;

	sf3_in_if  items ();
	sf3_out_if results ();

	spring_force_3d_core #(.FRAC_BITS(FRAC)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.results  (results),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// bench copy of the two registers
	logic [31:0] k_reg;
	logic [30:0] rest_reg;

	force_t expected_forces[$];   // predictions awaiting a result transaction
	force_t typed_answers[$];     // per driven item: typed answer, if any
	bit     typed_flags[$];

	int  errors;
	int  n_accepted;
	int  n_checked;
	int  n_zero;
	int  n_sat;
	bit  calm;        // no random idling on either side
	int  hold_reqs;   // long receiver hold-offs requested
	int  hold_done;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("timeout with %0d results outstanding", expected_forces.size());
		$display("** spring_force_3d_core: FAILED **");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint unsigned int_root(input longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Hooke force k*(rest-L)*d/L with truncation toward zero at each step.
	function automatic force_t hooke_force(input pair_t p);
		logic signed [31:0] pa[3];
		logic signed [31:0] ea[3];
		longint signed   dv;
		longint unsigned dm[3];
		bit              dneg[3];
		longint unsigned sum, len, m, u, fm;
		longint signed   e;
		bit              eneg, neg, sat;
		logic [31:0]     fr[3];
		force_t          res;
		pa[0] = p.px; pa[1] = p.py; pa[2] = p.pz;
		ea[0] = p.ex; ea[1] = p.ey; ea[2] = p.ez;
		sat = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			dv = longint'(pa[i]) - longint'(ea[i]);
			if (dv > 64'sd2147483647) begin
				dv = 64'sd2147483647;
				sat = 1;
			end else if (dv < -64'sd2147483648) begin
				dv = -64'sd2147483648;
				sat = 1;
			end
			dneg[i] = dv < 0;
			dm[i] = dneg[i] ? longint'(-dv) : longint'(dv);
			sum = sum + dm[i] * dm[i];
		end
		len = int_root(sum);
		if (len == 0) begin
			res = '{fx: 0, fy: 0, fz: 0, zl: 1'b1, sat: 1'b0};
			return res;
		end
		e = longint'({33'b0, rest_reg}) - longint'(len);
		eneg = e < 0;
		m = (longint'({32'b0, k_reg}) * (eneg ? -e : e)) >> FRAC;
		for (int i = 0; i < 3; i++) begin
			u = (dm[i] << FRAC) / len;
			fm = (m * u) >> FRAC;
			neg = (eneg != dneg[i]) && fm != 0;
			if (neg) begin
				if (fm > 64'h8000_0000) begin
					fm = 64'h8000_0000;
					sat = 1;
				end
				fr[i] = -fm[31:0];
			end else begin
				if (fm > 64'h7FFF_FFFF) begin
					fm = 64'h7FFF_FFFF;
					sat = 1;
				end
				fr[i] = fm[31:0];
			end
		end
		res = '{fx: fr[0], fy: fr[1], fz: fr[2], zl: 1'b0, sat: sat};
		return res;
	endfunction

	// ---------------------------------------------------------------- monitors

	// Input side: each accepted transaction queues its expected force.
	always @(posedge clk) begin
		if (arst_n && items.valid && items.ready) begin
			pair_t  p;
			force_t f;
			p = '{px: items.pos_x, py: items.pos_y, pz: items.pos_z,
				ex: items.end_x, ey: items.end_y, ez: items.end_z};
			f = hooke_force(p);
			if (typed_flags.pop_front())
				f = typed_answers.pop_front();
			else
				void'(typed_answers.pop_front());
			expected_forces.push_back(f);
			n_accepted++;
		end
	end

	// Output side: compare against the oldest expectation, field by field.
	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready) begin
			force_t x;
			force_t a;
			a = '{fx: results.force_x, fy: results.force_y, fz: results.force_z,
				zl: results.zero_length, sat: results.saturated};
			if (expected_forces.size() == 0) begin
				$display("%t unexpected result transaction fx=%h fy=%h fz=%h", $time,
					a.fx, a.fy, a.fz);
				errors++;
			end else begin
				x = expected_forces.pop_front();
				n_checked++;
				if (x.zl) n_zero++;
				if (x.sat) n_sat++;
				if (a.fx !== x.fx) begin
					$display("%t force_x expected %h got %h", $time, x.fx, a.fx);
					errors++;
				end
				if (a.fy !== x.fy) begin
					$display("%t force_y expected %h got %h", $time, x.fy, a.fy);
					errors++;
				end
				if (a.fz !== x.fz) begin
					$display("%t force_z expected %h got %h", $time, x.fz, a.fz);
					errors++;
				end
				if (a.zl !== x.zl) begin
					$display("%t zero_length expected %b got %b", $time, x.zl, a.zl);
					errors++;
				end
				if (a.sat !== x.sat) begin
					$display("%t saturated expected %b got %b", $time, x.sat, a.sat);
					errors++;
				end
			end
		end
	end

	// Receiver: random stalls, mostly short; a requested long hold-off keeps
	// ready low long enough for the internal queue to fill and items.ready to drop.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			results.ready <= 1'b0;
		end else if (hold_done < hold_reqs) begin
			hold_done++;
			stall_left = 300;
			results.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 3);
			results.ready <= 1'b0;
		end else begin
			results.ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- drivers

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == sf3_pkg::CFG_SPRING_CONSTANT)
			k_reg = value;
		else
			rest_reg = value[30:0];
	endtask

	// Registers change only with the pipeline empty.
	task automatic set_spring(input logic [31:0] k, input logic [31:0] rest);
		items.valid <= 1'b0;
		@(posedge clk);
		while (expected_forces.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		write_reg(sf3_pkg::CFG_SPRING_CONSTANT, k);
		write_reg(sf3_pkg::CFG_REST_LENGTH, rest);
	endtask

	// Offer one pair and hold it until the block takes it. The caller is at a
	// clock edge; valid stays high across back-to-back transactions.
	task automatic send_pair(input pair_t p, input bit typed, input force_t f);
		int gap;
		gap = calm ? 0 : (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
			: ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0));
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		typed_flags.push_back(typed);
		typed_answers.push_back(f);
		items.valid <= 1'b1;
		items.pos_x <= p.px;
		items.pos_y <= p.py;
		items.pos_z <= p.pz;
		items.end_x <= p.ex;
		items.end_y <= p.ey;
		items.end_z <= p.ez;
		do
			@(posedge clk);
		while (!items.ready);
	endtask

	function automatic logic signed [31:0] rand_offset();
		int sh;
		sh = $urandom_range(4, 30);
		return $signed($urandom() >> (32 - sh)) - $signed(32'(1) << (sh - 1));
	endfunction

	// Mostly near pairs (useful forces), with full-range, coincident and extreme ones.
	function automatic pair_t random_pair();
		pair_t p;
		int    mode;
		mode = $urandom_range(0, 9);
		p.ex = $urandom();
		p.ey = $urandom();
		p.ez = $urandom();
		if (mode <= 5) begin
			p.px = p.ex + rand_offset();
			p.py = p.ey + rand_offset();
			p.pz = p.ez + rand_offset();
		end else if (mode == 8) begin
			p.px = p.ex;
			p.py = p.ey;
			p.pz = p.ez;
		end else if (mode == 9) begin
			p.px = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			p.ex = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			p.py = $urandom();
			p.pz = $urandom_range(0, 1) ? p.ez : $urandom();
		end else begin
			p.px = $urandom();
			p.py = $urandom();
			p.pz = $urandom();
		end
		return p;
	endfunction

	// ---------------------------------------------------------------- stimulus

	localparam logic [31:0] ONE   = 32'h0001_0000;
	localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S_MIN = 32'h8000_0000;
	localparam force_t      NONE  = '{fx: 0, fy: 0, fz: 0, zl: 0, sat: 0};

	row_t directed[] = '{
		// register reset values, coincident ends
		'{0, 0, '{0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 1, 0}},
		// k = 0: no force; in the first two rows the x difference clamps
		'{0, 0, '{S_MAX, 0, 0, S_MIN, 0, 0}, 1, '{0, 0, 0, 0, 1}},
		'{0, 0, '{S_MIN, 0, 0, S_MAX, 0, 0}, 1, '{0, 0, 0, 0, 1}},
		'{0, 0, '{ONE, 0, 0, 0, 0, 0}, 1, NONE},
		// unit spring, zero rest length: pulled back by exactly its offset
		'{ONE, 0, '{ONE, 0, 0, 0, 0, 0}, 1, '{32'hFFFF_0000, 0, 0, 0, 0}},
		'{ONE, 0, '{0, ONE, 0, 0, 0, 0}, 1, '{0, 32'hFFFF_0000, 0, 0, 0}},
		'{ONE, 0, '{0, 0, 0, 0, 0, ONE}, 1, '{0, 0, ONE, 0, 0}},
		'{ONE, 0, '{5, -7, 9, 5, -7, 9}, 1, '{0, 0, 0, 1, 0}},
		'{ONE, 0, '{3 * ONE, 4 * ONE, 0, 0, 0, 0}, 0, NONE},
		'{ONE, 0, '{S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN}, 0, NONE},
		// rest length written with all bits set: top bit is dropped
		'{ONE, 32'hFFFF_FFFF, '{-ONE, 2 * ONE, -3 * ONE, ONE, 0, 0}, 0, NONE},
		'{ONE, 32'hFFFF_FFFF, '{1, 0, 0, 0, 0, 0}, 0, NONE},
		// largest k and rest: a tiny spring is hugely compressed
		'{32'hFFFF_FFFF, S_MAX, '{1, 0, 0, 0, 0, 0}, 1, '{S_MAX, 0, 0, 0, 1}},
		'{32'hFFFF_FFFF, S_MAX, '{0, 0, 0, 0, 0, 1}, 1, '{0, 0, S_MIN, 0, 1}},
		'{32'hFFFF_FFFF, S_MAX, '{-1, 1, 1, 0, 0, 0}, 0, NONE},
		'{32'hFFFF_FFFF, S_MAX, '{S_MIN, S_MAX, 0, S_MAX, S_MIN, 0}, 0, NONE},
		// rest length 5.0, equal to the length in the first row: no force there
		'{32'h0003_0000, 5 * ONE, '{3 * ONE, 4 * ONE, 0, 0, 0, 0}, 1, NONE},
		'{32'h0003_0000, 5 * ONE, '{7 * ONE, -ONE, 2, 0, 3, -4}, 0, NONE},
		'{32'h0003_0000, 5 * ONE, '{32'h1234_5678, -32'h0765_4321, 32'h0ABC_DEF0,
			-32'h0111_1111, 32'h0222_2222, -32'h0333_3333}, 0, NONE}
	};

	initial begin
		logic [31:0] last_k, last_rest;
		pair_t       p;
		logic [31:0] kset[5];
		logic [31:0] rset[5];

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = sf3_pkg::CFG_SPRING_CONSTANT;
		cfg_data     = '0;
		items.valid  = 1'b0;
		items.pos_x  = '0;
		items.pos_y  = '0;
		items.pos_z  = '0;
		items.end_x  = '0;
		items.end_y  = '0;
		items.end_z  = '0;
		k_reg        = '0;
		rest_reg     = '0;
		errors       = 0;
		n_accepted   = 0;
		n_checked    = 0;
		n_zero       = 0;
		n_sat        = 0;
		calm         = 1'b0;
		hold_reqs    = 0;
		hold_done    = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: registers rewritten whenever a row asks for a new setting.
		last_k    = '0;
		last_rest = '0;
		foreach (directed[i]) begin
			if (directed[i].k != last_k || directed[i].rest != last_rest) begin
				set_spring(directed[i].k, directed[i].rest);
				last_k    = directed[i].k;
				last_rest = directed[i].rest;
			end
			send_pair(directed[i].p, directed[i].typed, directed[i].f);
		end

		// Random phases over several spring settings, extremes included.
		kset = '{ONE, 32'hFFFF_FFFF, 32'h0000_0001, $urandom(), $urandom_range(0, 32'h000F_FFFF)};
		rset = '{5 * ONE, 0, S_MAX, $urandom(), $urandom_range(0, 32'h00FF_FFFF)};
		for (int ph = 0; ph < 5; ph++) begin
			set_spring(kset[ph], rset[ph]);
			calm = (ph == 3);
			if (ph == 1)
				hold_reqs++;
			for (int n = 0; n < 120; n++) begin
				p = random_pair();
				send_pair(p, 1'b0, NONE);
			end
		end
		calm = 1'b0;
		items.valid <= 1'b0;

		while (expected_forces.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		$display("covered %0d transactions over 5 random spring settings plus the table;",
			n_accepted);
		$display("%0d results checked, %0d with coincident ends, %0d clamped",
			n_checked, n_zero, n_sat);
		if (errors == 0)
			$display("** spring_force_3d_core: PASSED **");
		else
			$display("** spring_force_3d_core: FAILED **");
		$finish;
	end

endmodule
